// ===== src/bqx_pkg.sv =====
// Shared types, constants, coefficient ROM and microprogram of the biquad crossover.
package bqx_pkg;

    // Number formats
    localparam int COEF_WIDTH  = 32;
    localparam int STATE_WIDTH = 32;
    localparam int NUM_RATES   = 4;
    localparam int CFRAC       = COEF_WIDTH - 2;
    localparam int SFRAC       = STATE_WIDTH - 18;

    // ROM scaling from its stored Q2.30 form to Q2.CFRAC
    localparam int ROM_FRAC  = 30;
    localparam int COEF_UP   = (CFRAC >= ROM_FRAC) ? (CFRAC - ROM_FRAC) : 0;
    localparam int COEF_DOWN = (CFRAC < ROM_FRAC) ? (ROM_FRAC - CFRAC) : 0;
    localparam int COEF_DM1  = (COEF_DOWN > 0) ? (COEF_DOWN - 1) : 0;
    localparam logic signed [63:0] COEF_RND = (COEF_DOWN > 0) ? (64'sd1 <<< COEF_DM1) : 64'sd0;

    // Configuration register indexes and values
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_RATE = 1'b1;
    localparam logic [1:0] MODE_LEFT  = 2'd0;
    localparam logic [1:0] MODE_RIGHT = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd0;
    localparam logic [1:0] RATE_RESET = 2'd3;

    // Physical filter slots
    localparam logic [1:0] PF_HP45  = 2'd0;
    localparam logic [1:0] PF_LP2K5 = 2'd1;
    localparam logic [1:0] PF_LP230 = 2'd2;
    localparam logic [1:0] PF_HP28  = 2'd3;

    // Coefficient kinds in a ROM row
    localparam int K_A0 = 0;
    localparam int K_B1 = 1;
    localparam int K_B2 = 2;

    // [filter][rate][a0, b1, b2] in Q2.30
    localparam logic signed [31:0] COEF_ROM [4][4][3] = '{
        '{ '{ 32'sd1060408117, -32'sd2120650653, 32'sd1047239991 },
           '{ 32'sd1067054145, -32'sd2134066637, 32'sd1060408119 },
           '{ 32'sd1068884929, -32'sd2137747889, 32'sd1064050003 },
           '{ 32'sd1069278730, -32'sd2138538910, 32'sd1064834187 } },
        '{ '{ 32'sd150250263, -32'sd751295974, 32'sd278555202 },
           '{ 32'sd47543180, -32'sd1420385853, 32'sd536816749 },
           '{ 32'sd27031840, -32'sd1614532345, 32'sd648917879 },
           '{ 32'sd23214420, -32'sd1656867353, 32'sd675983210 } },
        '{ '{ 32'sd2057160, -32'sd2010499983, 32'sd944986800 },
           '{ 32'sd530438, -32'sd2078929187, 32'sd1007309113 },
           '{ 32'sd281704, -32'sd2097731382, 32'sd1025116372 },
           '{ 32'sd238228, -32'sd2101772538, 32'sd1028983626 } },
        '{ '{ 32'sd478886325, -32'sd598105262, 32'sd243698216 },
           '{ 32'sd726289477, -32'sd1337040167, 32'sd494375915 },
           '{ 32'sd809297072, -32'sd1552448052, 32'sd610998414 },
           '{ 32'sd828209210, -32'sd1599519518, 32'sd639575499 } }
    };

    // Look up one coefficient and bring it to the working format
    function automatic logic signed [COEF_WIDTH-1:0] coef_q(input logic [1:0] f,
                                                          input logic [1:0] r,
                                                          input int k);
        logic signed [63:0] v;
        v = 64'(COEF_ROM[f][r][k]);
        v = ((v <<< COEF_UP) + COEF_RND) >>> COEF_DOWN;
        return v[COEF_WIDTH-1:0];
    endfunction

    // Control word fields
    typedef enum logic [1:0] {
        CS_A0  = 2'd0,
        CS_A1  = 2'd1,
        CS_NB1 = 2'd2,
        CS_NB2 = 2'd3
    } t_coef_sel;

    typedef enum logic {
        OP_X   = 1'b0,
        OP_TAP = 1'b1
    } t_opnd_sel;

    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } t_acc_op;

    typedef enum logic [1:0] {
        WR_X   = 2'd0,
        WR_TAP = 2'd1,
        WR_Y   = 2'd2
    } t_wr_src;

    typedef enum logic [1:0] {
        X_HOLD     = 2'd0,
        X_FROM_Y   = 2'd1,
        X_FROM_SRC = 2'd2
    } t_x_ld;

    typedef enum logic [1:0] {
        OUT_NONE = 2'd0,
        OUT_LOW  = 2'd1,
        OUT_HIGH = 2'd2
    } t_out_ld;

    // Logical filter: the low-pass slot follows the mode
    typedef enum logic [1:0] {
        FLT_HP45 = 2'd0,
        FLT_LP   = 2'd1,
        FLT_HP28 = 2'd2
    } t_filt;

    // Program layout: eight steps per filter, then a hand-off step
    localparam int STEPS_PER_FILT = 8;
    localparam int NUM_STEPS      = 3 * STEPS_PER_FILT + 1;
    localparam int PC_W           = $clog2(NUM_STEPS);
    localparam logic [PC_W-1:0] STEP_F0_END = PC_W'(STEPS_PER_FILT - 1);
    localparam logic [PC_W-1:0] STEP_LP_END = PC_W'(2 * STEPS_PER_FILT - 1);
    localparam logic [PC_W-1:0] STEP_HP_END = PC_W'(3 * STEPS_PER_FILT - 1);
    localparam logic [PC_W-1:0] STEP_DONE   = PC_W'(3 * STEPS_PER_FILT);

    typedef struct packed {
        logic            rd_en;
        logic [1:0]      rd_idx;
        logic            mul_en;
        t_coef_sel       coef_sel;
        t_opnd_sel       opnd_sel;
        t_acc_op         acc_op;
        logic            nar_en;
        logic            wr_en;
        logic [1:0]      wr_idx;
        t_wr_src         wr_src;
        t_x_ld           x_ld;
        t_out_ld         out_ld;
        t_filt           filt;
        logic            jmp_sub;
        logic [PC_W-1:0] jmp_tgt;
        logic            done;
    } t_ctl;

    localparam t_ctl CTL_NOP = t_ctl'('0);

    // One step of a biquad: read taps, multiply, accumulate, narrow, shift the taps
    function automatic t_ctl filt_step(input logic [2:0] t);
        t_ctl c;
        c = CTL_NOP;
        unique case (t)
            3'd0: begin
                c.rd_en = 1'b1; c.rd_idx = 2'd0;
                c.mul_en = 1'b1; c.coef_sel = CS_A0; c.opnd_sel = OP_X;
            end
            3'd1: begin
                c.rd_en = 1'b1; c.rd_idx = 2'd1;
                c.mul_en = 1'b1; c.coef_sel = CS_A1; c.opnd_sel = OP_TAP;
                c.acc_op = ACC_LOAD;
                c.wr_en = 1'b1; c.wr_idx = 2'd1; c.wr_src = WR_TAP;
            end
            3'd2: begin
                c.rd_en = 1'b1; c.rd_idx = 2'd2;
                c.mul_en = 1'b1; c.coef_sel = CS_A0; c.opnd_sel = OP_TAP;
                c.acc_op = ACC_ADD;
                c.wr_en = 1'b1; c.wr_idx = 2'd0; c.wr_src = WR_X;
            end
            3'd3: begin
                c.rd_en = 1'b1; c.rd_idx = 2'd3;
                c.mul_en = 1'b1; c.coef_sel = CS_NB1; c.opnd_sel = OP_TAP;
                c.acc_op = ACC_ADD;
                c.wr_en = 1'b1; c.wr_idx = 2'd3; c.wr_src = WR_TAP;
            end
            3'd4: begin
                c.mul_en = 1'b1; c.coef_sel = CS_NB2; c.opnd_sel = OP_TAP;
                c.acc_op = ACC_ADD;
            end
            3'd5: begin
                c.acc_op = ACC_ADD;
            end
            3'd6: begin
                c.nar_en = 1'b1;
            end
            3'd7: begin
                c.wr_en = 1'b1; c.wr_idx = 2'd2; c.wr_src = WR_Y;
            end
            default: begin
                c = CTL_NOP;
            end
        endcase
        return c;
    endfunction

    // Microprogram ROM
    function automatic t_ctl ucode(input logic [PC_W-1:0] pc);
        t_ctl c;
        c = CTL_NOP;
        if (pc == STEP_DONE) begin
            c.done = 1'b1;
        end else if (pc < STEP_DONE) begin
            c = filt_step(pc[2:0]);
            c.filt = t_filt'(pc[PC_W-1:3]);
        end
        // Chain the filters and collect outputs after the low-pass and the last high-pass
        if (pc == STEP_F0_END) begin
            c.x_ld = X_FROM_Y;
        end
        if (pc == STEP_LP_END) begin
            c.x_ld    = X_FROM_SRC;
            c.out_ld  = OUT_LOW;
            c.jmp_sub = 1'b1;
            c.jmp_tgt = STEP_DONE;
        end
        if (pc == STEP_HP_END) begin
            c.out_ld = OUT_HIGH;
        end
        return c;
    endfunction

endpackage

// ===== src/bqx_regs.sv =====
// APB-style configuration registers: mode and sample-rate select.
module bqx_regs
    import bqx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [1:0]            o_mode,
    output logic [1:0]            o_rate
);

    logic [1:0] r_mode;
    logic [1:0] r_rate;
    logic       wr_fire;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // Write on the access phase of a write transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
            r_rate <= RATE_RESET;
        end else if (wr_fire) begin
            unique case (reg_sel)
                REG_MODE: r_mode <= pwdata[1:0];
                REG_RATE: r_rate <= pwdata[1:0];
                default:  r_mode <= r_mode;
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        unique case (reg_sel)
            REG_MODE: prdata = {30'd0, r_mode};
            REG_RATE: prdata = {30'd0, r_rate};
            default:  prdata = 32'd0;
        endcase
    end

    assign o_mode = r_mode;
    assign o_rate = r_rate;

endmodule

// ===== src/bqx_sequencer.sv =====
// Microcode sequencer: step counter, control ROM fetch and conditional jump.
module bqx_sequencer
    import bqx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_sub,
    input  logic i_out_free,
    output t_ctl o_ctl,
    output logic o_busy,
    output logic o_fire
);

    logic [PC_W-1:0] r_pc;
    logic            r_busy;
    t_ctl            word;

    assign word   = ucode(r_pc);
    assign o_ctl  = r_busy ? word : CTL_NOP;
    assign o_busy = r_busy;
    assign o_fire = r_busy && word.done && i_out_free;

    // Advance through the program; hold on the final step until the output is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_busy <= 1'b0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_pc   <= '0;
                r_busy <= 1'b1;
            end
        end else if (word.done) begin
            if (i_out_free) begin
                r_pc   <= '0;
                r_busy <= 1'b0;
            end
        end else if (word.jmp_sub && i_sub) begin
            r_pc <= word.jmp_tgt;
        end else begin
            r_pc <= r_pc + PC_W'(1);
        end
    end

endmodule

// ===== src/bqx_datapath.sv =====
// Biquad datapath: delay taps, coefficient select, multiplier, accumulator, output scaling.
module bqx_datapath
    import bqx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    input  logic               i_start,
    input  logic [1:0]         i_mode,
    input  logic [1:0]         i_rate,
    input  logic signed [15:0] i_left,
    input  logic signed [15:0] i_right,
    output logic signed [15:0] o_low,
    output logic signed [15:0] o_high
);

    localparam int CW      = COEF_WIDTH;
    localparam int SW      = STATE_WIDTH;
    localparam int PROD_W  = CW + 1 + SW;
    localparam int ACC_W   = PROD_W + 3;
    localparam int NTAPS   = 16;
    localparam int TAP_W   = $clog2(NTAPS);

    localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN = {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [SW:0] TRUNC_BIAS = {{(SW+1-SFRAC){1'b0}}, {SFRAC{1'b1}}};
    localparam logic signed [SW:0] OUT_MAX    = {{(SW+1-15){1'b0}}, {15{1'b1}}};
    localparam logic signed [SW:0] OUT_MIN    = {{(SW+1-15){1'b1}}, {15{1'b0}}};

    logic signed [SW-1:0]     r_taps [NTAPS];
    logic signed [SW-1:0]     r_tap;
    logic signed [SW-1:0]     r_x;
    logic signed [SW-1:0]     r_src;
    logic signed [SW-1:0]     r_y;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [15:0]       r_low;
    logic signed [15:0]       r_high;

    logic                     sub;
    logic [1:0]               row;
    logic [1:0]               phys;
    logic                     is_hp;
    logic signed [CW-1:0]     a0;
    logic signed [CW-1:0]     b1;
    logic signed [CW-1:0]     b2;
    logic signed [CW:0]       coef_op;
    logic signed [SW-1:0]     opnd;
    logic signed [16:0]       src17;
    logic signed [SW-1:0]     x_src;
    logic signed [ACC_W-1:0]  acc_sh;
    logic signed [SW-1:0]     n_y;
    logic signed [SW-1:0]     wr_data;
    logic [TAP_W-1:0]         rd_addr;
    logic [TAP_W-1:0]         wr_addr;
    logic signed [15:0]       y16;

    // Truncate toward zero to an integer and saturate to int16
    function automatic logic signed [15:0] to_out16(input logic signed [SW-1:0] y);
        logic signed [SW:0] ys;
        logic signed [SW:0] q;
        ys = (SW+1)'(y) + (y[SW-1] ? TRUNC_BIAS : '0);
        q  = ys >>> SFRAC;
        if (q > OUT_MAX) begin
            q = OUT_MAX;
        end else if (q < OUT_MIN) begin
            q = OUT_MIN;
        end
        return q[15:0];
    endfunction

    assign sub = (i_mode != MODE_LEFT) && (i_mode != MODE_RIGHT);
    assign row = (32'(i_rate) >= NUM_RATES) ? 2'(NUM_RATES - 1) : i_rate;

    // Map the logical filter of this step onto its tap and ROM slot
    always_comb begin
        unique case (i_ctl.filt)
            FLT_HP45: phys = PF_HP45;
            FLT_LP:   phys = sub ? PF_LP230 : PF_LP2K5;
            FLT_HP28: phys = PF_HP28;
            default:  phys = PF_HP45;
        endcase
    end

    assign is_hp = (phys == PF_HP45) || (phys == PF_HP28);
    assign a0    = coef_q(phys, row, K_A0);
    assign b1    = coef_q(phys, row, K_B1);
    assign b2    = coef_q(phys, row, K_B2);

    // Select the coefficient operand; feedback terms enter negated
    always_comb begin
        unique case (i_ctl.coef_sel)
            CS_A0:   coef_op = (CW+1)'(a0);
            CS_A1:   coef_op = is_hp ? -((CW+1)'(a0) <<< 1) : ((CW+1)'(a0) <<< 1);
            CS_NB1:  coef_op = -(CW+1)'(b1);
            CS_NB2:  coef_op = -(CW+1)'(b2);
            default: coef_op = '0;
        endcase
    end

    assign opnd = (i_ctl.opnd_sel == OP_TAP) ? r_tap : r_x;

    // Form the mono source in the tap format
    always_comb begin
        if (i_mode == MODE_LEFT) begin
            src17 = 17'(i_left) <<< 1;
        end else if (i_mode == MODE_RIGHT) begin
            src17 = 17'(i_right) <<< 1;
        end else begin
            src17 = 17'(i_left) + 17'(i_right);
        end
        x_src = SW'(src17) <<< SFRAC;
    end

    // Floor the sum to the tap format and saturate
    always_comb begin
        acc_sh = r_acc >>> CFRAC;
        if (acc_sh > SMAX) begin
            n_y = SMAX[SW-1:0];
        end else if (acc_sh < SMIN) begin
            n_y = SMIN[SW-1:0];
        end else begin
            n_y = acc_sh[SW-1:0];
        end
    end

    always_comb begin
        unique case (i_ctl.wr_src)
            WR_X:    wr_data = r_x;
            WR_TAP:  wr_data = r_tap;
            WR_Y:    wr_data = r_y;
            default: wr_data = r_x;
        endcase
    end

    assign rd_addr = {phys, i_ctl.rd_idx};
    assign wr_addr = {phys, i_ctl.wr_idx};
    assign y16     = to_out16(r_y);

    // Delay taps: cleared by reset, at most one write per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NTAPS; i++) begin
                r_taps[i] <= '0;
            end
        end else if (i_ctl.wr_en) begin
            r_taps[wr_addr] <= wr_data;
        end
    end

    // Tap read, multiply, accumulate and narrow stages
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_tap <= r_taps[rd_addr];
        end
        if (i_ctl.mul_en) begin
            r_prod <= coef_op * opnd;
        end
        unique case (i_ctl.acc_op)
            ACC_LOAD: r_acc <= ACC_W'(r_prod);
            ACC_ADD:  r_acc <= r_acc + ACC_W'(r_prod);
            default:  r_acc <= r_acc;
        endcase
        if (i_ctl.nar_en) begin
            r_y <= n_y;
        end
    end

    // Filter input and source
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= x_src;
            r_src <= x_src;
        end else begin
            unique case (i_ctl.x_ld)
                X_FROM_Y:   r_x <= r_y;
                X_FROM_SRC: r_x <= r_src;
                default:    r_x <= r_x;
            endcase
        end
    end

    // Capture outputs; subwoofer mode copies the low result to both
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.out_ld)
            OUT_LOW: begin
                r_low <= y16;
                if (sub) begin
                    r_high <= y16;
                end
            end
            OUT_HIGH: r_high <= y16;
            default:  r_low  <= r_low;
        endcase
    end

    assign o_low  = r_low;
    assign o_high = r_high;

endmodule

// ===== src/biquad_audio_crossover_top.sv =====
// Top level of the two-way / subwoofer biquad crossover.
//
// Input channel: i_valid / o_stall carry one stereo frame (i_left_sample,
// i_right_sample, i_frame_last); a transaction completes when i_valid is
// high and o_stall is low. Output channel: o_valid / i_stall carry one
// result (o_low_out, o_high_out, o_last) per frame.
// Configuration: APB-style port, register 0 (mode) at 0x0, register 1
// (rate select) at 0x4; write only while no frame is in flight.
// Each frame runs a 25-step microprogram on one shared multiply-accumulate
// datapath (eight steps per biquad, three biquads, one hand-off step). A new
// frame is taken only while the sequencer is idle, so it cannot start before
// the previous frame is handed off. In subwoofer mode the program skips the
// third biquad.
// A finished result waits in the output register; the next frame is taken
// and processed meanwhile, and the sequencer holds on its last step while
// the receiver stalls. Reset clears all delay taps, sets mode 0 and
// rate select 3, and empties the output register.
module biquad_audio_crossover_top
    import bqx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [15:0]    i_left_sample,
    input  logic signed [15:0]    i_right_sample,
    input  logic                  i_frame_last,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [15:0]    o_low_out,
    output logic signed [15:0]    o_high_out,
    output logic                  o_last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic               r_ovalid;
    logic               r_last;
    logic [1:0]         mode;
    logic [1:0]         rate;
    logic               busy;
    logic               fire;
    logic               start;
    logic               out_free;
    logic               sub;
    t_ctl               ctl;
    logic signed [15:0] low16;
    logic signed [15:0] high16;

    assign start    = i_valid && !busy;
    assign out_free = !r_ovalid || !i_stall;
    assign sub      = (mode != MODE_LEFT) && (mode != MODE_RIGHT);
    assign o_stall  = busy;

    bqx_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (mode),
        .o_rate  (rate)
    );

    bqx_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_sub      (sub),
        .i_out_free (out_free),
        .o_ctl      (ctl),
        .o_busy     (busy),
        .o_fire     (fire)
    );

    bqx_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_start (start),
        .i_mode  (mode),
        .i_rate  (rate),
        .i_left  (i_left_sample),
        .i_right (i_right_sample),
        .o_low   (low16),
        .o_high  (high16)
    );

    // Hold the end-of-buffer mark with the frame in flight
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_last <= i_frame_last;
        end
    end

    // Output register: load on hand-off, drop when the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fire) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_low_out  <= low16;
            o_high_out <= high16;
            o_last     <= r_last;
        end
    end

    assign o_valid = r_ovalid;

endmodule
